>>> rtl/amgt_pkg.sv
// Package: shared types, mode codes and constants for the graph table.
`default_nettype none
package amgt_pkg;
  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [3:0] MODE_ADDV = 4'd0;
  localparam logic [3:0] MODE_ADDE = 4'd1;
  localparam logic [3:0] MODE_REME = 4'd2;
  localparam logic [3:0] MODE_REMV = 4'd3;
  localparam logic [3:0] MODE_ADJ = 4'd4;
  localparam logic [3:0] MODE_NBR = 4'd5;
  localparam logic [3:0] MODE_INDEG = 4'd6;
  localparam logic [3:0] MODE_OUTDEG = 4'd7;
  localparam logic [3:0] MODE_DEGREE = 4'd8;
  localparam logic [3:0] MODE_EDGES = 4'd9;
  localparam logic [3:0] MODE_VERTS = 4'd10;
  localparam logic [3:0] MODE_EMPTY = 4'd11;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] vertex_a;
    logic [7:0] vertex_b;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        flag;
    logic [15:0] neighbour_mask;
    logic [7:0]  count;
  } res_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture word, clear accumulators
    logic scan_en;  // process row at scan index
    logic clr_idx;  // restart scan index
    logic done;     // form and strobe result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;     // scan index at final row
  } dp_sts_t;
endpackage
`default_nettype wire

>>> rtl/amgt_ctrl.sv
// Controller: sequences lookup scan, work scan and result.
`default_nettype none
module amgt_ctrl
  import amgt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  output dp_cmd_t      cmd,
  input  dp_sts_t      sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_WORK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // two row scans: name lookup, then matrix work
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.scan_en = 1'b1;
        if (sts.last) begin
          cmd.clr_idx = 1'b1;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        cmd.scan_en = 1'b1;
        if (sts.last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

>>> rtl/amgt_dp.sv
// Datapath: vertex table, adjacency matrix and per-row scan logic.
`default_nettype none
module amgt_dp
  import amgt_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_word_t cmd_in,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      strobe,
  output res_word_t result
);
  localparam int NV = MAX_VERTICES;
  localparam int IW = $clog2(NV);
  localparam int UW = $clog2(NV + 1);
  localparam int CW = $clog2(2 * NV + 1);
  localparam int EW = $clog2(NV * NV + 1);
  localparam int MW = (NV < 16) ? NV : 16;

  logic [7:0]    names [NV];
  logic [NV-1:0] valid;
  logic [NV-1:0] adj [NV];
  logic [UW-1:0] used;

  cmd_word_t     word;
  logic [IW-1:0] idx;
  logic          pass;       // 0 lookup, 1 work
  logic          fa, fb;
  logic [IW-1:0] sa, sb;
  logic [CW-1:0] cnt;
  logic [EW-1:0] ecnt;
  logic          flg;
  logic [15:0]   msk;
  logic          wfull;      // table was full when the word was taken

  assign sts.last = (idx == IW'(NV - 1));

  logic          in_used;
  logic          ok_ab, ok_a, full;
  logic [NV-1:0] row;
  logic [CW-1:0] row_pop;
  logic [CW-1:0] tri_pop;

  assign in_used = ({1'b0, idx} < (IW + 1)'(used)) || (UW > IW && used[UW-1]);
  assign ok_ab = fa && fb;
  assign ok_a  = fa;
  assign full  = (used == UW'(NV));
  assign row   = adj[idx];

  // popcount of the current row, and of its upper triangle
  always_comb begin
    row_pop = '0;
    tri_pop = '0;
    for (int j = 0; j < NV; j++) begin
      row_pop = row_pop + CW'(row[j]);
      if (j >= int'(idx)) tri_pop = tri_pop + CW'(row[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
      for (int i = 0; i < NV; i++) adj[i] <= '0;
      idx <= '0;
      pass <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.done;
      if (cmd.load) begin
        word <= cmd_in;
        idx <= '0;
        pass <= 1'b0;
        fa <= 1'b0;
        fb <= 1'b0;
        cnt <= '0;
        ecnt <= '0;
        flg <= 1'b0;
        msk <= '0;
        wfull <= full;
      end
      if (cmd.scan_en) begin
        idx <= cmd.clr_idx ? '0 : idx + IW'(1);
        if (!pass) begin
          // lookup: first valid matching slot
          if (in_used && valid[idx]) begin
            if (!fa && names[idx] == word.vertex_a) begin
              fa <= 1'b1;
              sa <= idx;
            end
            if (!fb && names[idx] == word.vertex_b) begin
              fb <= 1'b1;
              sb <= idx;
            end
          end
        end else begin
          // work pass: one row per cycle
          case (word.mode)
            MODE_ADDV: begin
              if (!full) begin
                if (idx == used[IW-1:0]) adj[idx] <= '0;
                else adj[idx][used[IW-1:0]] <= 1'b0;
              end
            end
            MODE_ADDE: begin
              // a self loop hits the same bit from both ends
              if (ok_ab && (idx == sa || idx == sb)) adj[idx][(idx == sa) ? sb : sa] <= 1'b1;
            end
            MODE_REME: begin
              if (ok_ab && (idx == sa || idx == sb)) adj[idx][(idx == sa) ? sb : sa] <= 1'b0;
            end
            MODE_REMV: begin
              if (ok_a) begin
                if (idx == sa) adj[idx] <= '0;
                else adj[idx][sa] <= 1'b0;
              end
            end
            MODE_ADJ: begin
              if (ok_ab && idx == sa) flg <= row[sb];
            end
            MODE_NBR: begin
              if (ok_a && idx == sa) begin
                for (int j = 0; j < MW; j++) msk[j] <= row[j] && (j != int'(sa));
              end
            end
            MODE_INDEG, MODE_OUTDEG, MODE_DEGREE: begin
              if (ok_a) begin
                cnt <= cnt
                     + ((word.mode != MODE_OUTDEG) ? CW'(row[sa]) : CW'(0))
                     + ((word.mode != MODE_INDEG && idx == sa) ? row_pop : CW'(0));
              end
            end
            MODE_EDGES: ecnt <= ecnt + EW'(tri_pop);
            MODE_VERTS, MODE_EMPTY: cnt <= cnt + CW'(valid[idx]);
            default: ;
          endcase
        end
        if (cmd.clr_idx) pass <= 1'b1;
      end
      // table update at the end of the item
      if (cmd.done) begin
        if (word.mode == MODE_ADDV && !full) begin
          names[used[IW-1:0]] <= word.vertex_a;
          valid[used[IW-1:0]] <= 1'b1;
          used <= used + UW'(1);
        end
        if (word.mode == MODE_REMV && ok_a) valid[sa] <= 1'b0;
      end
    end
  end

  // result formatting
  always_comb begin
    result = '0;
    case (word.mode)
      MODE_ADDV: if (wfull) result.status = ST_FULL;
      MODE_ADDE, MODE_REME: if (!ok_ab) result.status = ST_MISSING;
      MODE_ADJ: begin
        if (!ok_ab) result.status = ST_MISSING;
        else result.flag = flg;
      end
      MODE_REMV: if (!ok_a) result.status = ST_MISSING;
      MODE_NBR: begin
        if (!ok_a) result.status = ST_MISSING;
        else result.neighbour_mask = msk;
      end
      MODE_INDEG, MODE_OUTDEG, MODE_DEGREE: begin
        if (!ok_a) result.status = ST_MISSING;
        else result.count = 8'(cnt);
      end
      MODE_EDGES: result.count = (ecnt > EW'(255)) ? 8'd255 : 8'(ecnt);
      MODE_VERTS: result.count = 8'(cnt);
      MODE_EMPTY: result.flag = (cnt == '0);
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/adjacency_matrix_graph_table_top.sv
// Top level: undirected graph table with adjacency bit matrix.
// done rises after a row-per-cycle name lookup scan, a row-per-cycle matrix
// scan and an update state; busy falls as done rises, so the table takes a new
// word only after the previous one has finished.
// The receiver cannot stall; done marks the result for one cycle.
// Synchronous reset clears valid bits, slot count and the matrix at once.
`default_nettype none
module adjacency_matrix_graph_table_top
  import amgt_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  cmd_word_t cmd,
  output logic      done,
  output res_word_t result
);
  dp_cmd_t dcmd;
  dp_sts_t dsts;

  amgt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(dcmd), .sts(dsts)
  );

  amgt_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .rst(rst), .cmd_in(cmd), .cmd(dcmd), .sts(dsts),
    .strobe(done), .result(result)
  );
endmodule
`default_nettype wire

>>> rtl/amgt_checker.sv
// Checker: port-level properties of the graph table, bound to the top level.
`default_nettype none
module amgt_checker
  import amgt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input res_word_t result
);
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy) && !$past(rst)) |-> !done) else $error("early done");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3)) else $error("bad status");
endmodule

bind adjacency_matrix_graph_table_top amgt_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
`default_nettype wire
